// ===== sv/arsa_pkg.sv =====
package arsa_pkg;

	localparam int unsigned CNT_WIDTH_DEF   = 64;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// SAM flag bit positions
	localparam int unsigned FB_PAIRED    = 0;
	localparam int unsigned FB_PROPER    = 1;
	localparam int unsigned FB_UNMAP     = 2;
	localparam int unsigned FB_MUNMAP    = 3;
	localparam int unsigned FB_READ1     = 6;
	localparam int unsigned FB_READ2     = 7;
	localparam int unsigned FB_SECONDARY = 8;
	localparam int unsigned FB_QCFAIL    = 9;
	localparam int unsigned FB_DUP       = 10;
	localparam int unsigned FB_SUPP      = 11;

	// CIGAR operations that add to the base count
	localparam logic [3:0] CIG_M  = 4'd0;
	localparam logic [3:0] CIG_I  = 4'd1;
	localparam logic [3:0] CIG_EQ = 4'd7;
	localparam logic [3:0] CIG_X  = 4'd8;

	// Counter slots. The last three are running sums kept alongside so that
	// a read is a plain select.
	localparam int unsigned C_FILT      = 0;
	localparam int unsigned C_FIRST     = 1;
	localparam int unsigned C_LAST      = 2;
	localparam int unsigned C_OTHER     = 3;
	localparam int unsigned C_UNMAPPED  = 4;
	localparam int unsigned C_SINGLE    = 5;
	localparam int unsigned C_PAIRMAP   = 6;
	localparam int unsigned C_PROPER    = 7;
	localparam int unsigned C_PAIRTECH  = 8;
	localparam int unsigned C_ANOM      = 9;
	localparam int unsigned C_DUP       = 10;
	localparam int unsigned C_MQ0       = 11;
	localparam int unsigned C_QCFAIL    = 12;
	localparam int unsigned C_SECONDARY = 13;
	localparam int unsigned C_SUPP      = 14;
	localparam int unsigned C_TLEN      = 15;
	localparam int unsigned C_TLEN1     = 16;
	localparam int unsigned C_TLEN2     = 17;
	localparam int unsigned C_TLENDUP   = 18;
	localparam int unsigned C_BMAPPED   = 19;
	localparam int unsigned C_BCIGAR    = 20;
	localparam int unsigned C_NM        = 21;
	localparam int unsigned C_SEQS      = 22;
	localparam int unsigned C_MAPPED    = 23;
	localparam int unsigned C_RAW       = 24;
	localparam int unsigned NCNT        = 25;

	localparam int unsigned SUM_COUNT = 24;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_CIGAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_COUNTED   = 2'd0,
		ST_SKIPPED   = 2'd1,
		ST_NO_CIGAR  = 2'd2,
		ST_BAD_CIGAR = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		CFG_MIN_MAPQ = 4'd0,
		CFG_REQUIRE  = 4'd1,
		CFG_EXCLUDE  = 4'd2,
		CFG_HIDE     = 4'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		SUM_RAW_TOTAL    = 5'd0,
		SUM_FILTERED     = 5'd1,
		SUM_SEQUENCES    = 5'd2,
		SUM_FIRST        = 5'd3,
		SUM_LAST         = 5'd4,
		SUM_OTHER        = 5'd5,
		SUM_MAPPED       = 5'd6,
		SUM_PAIR_MAPPED  = 5'd7,
		SUM_UNMAPPED     = 5'd8,
		SUM_PROPER       = 5'd9,
		SUM_PAIRED       = 5'd10,
		SUM_DUP          = 5'd11,
		SUM_MQ0          = 5'd12,
		SUM_QCFAIL       = 5'd13,
		SUM_SECONDARY    = 5'd14,
		SUM_SUPP         = 5'd15,
		SUM_DIFF_REF     = 5'd16,
		SUM_TOTAL_LEN    = 5'd17,
		SUM_FIRST_LEN    = 5'd18,
		SUM_LAST_LEN     = 5'd19,
		SUM_BASES_MAPPED = 5'd20,
		SUM_BASES_CIGAR  = 5'd21,
		SUM_BASES_DUP    = 5'd22,
		SUM_NM           = 5'd23
	} sum_idx_t;

	typedef enum logic [1:0] {
		SRC_ONE,
		SRC_LEN,
		SRC_NM,
		SRC_CIG
	} src_t;

	typedef struct packed {
		logic [7:0]  mapq_floor;
		logic [11:0] require_mask;
		logic [11:0] exclude_mask;
	} filt_cfg_t;

	typedef struct packed {
		status_t          status;
		logic             is_counter;
		logic [NCNT-1:0]  inc;
		logic [23:0]      seq_len;
		logic [23:0]      nm;
		logic [27:0]      cig_len;
		logic [4:0]       rd_idx;
	} cmd_t;

	function automatic src_t cnt_src(input int unsigned idx);
		src_t s;
		case (idx)
			C_TLEN, C_TLEN1, C_TLEN2, C_TLENDUP, C_BMAPPED: s = SRC_LEN;
			C_NM:     s = SRC_NM;
			C_BCIGAR: s = SRC_CIG;
			default:  s = SRC_ONE;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/arsa_fifo.sv =====
module arsa_fifo import arsa_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             nonempty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/arsa_front.sv =====
module arsa_front import arsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  filt_cfg_t   cfg,
	input  logic [1:0]  opcode,
	input  logic [11:0] flags,
	input  logic [7:0]  mapq,
	input  logic [23:0] seq_len,
	input  logic        same_reference,
	input  logic        nm_present,
	input  logic [23:0] nm_value,
	input  logic [15:0] cigar_count,
	input  logic [3:0]  cigar_op,
	input  logic [27:0] cigar_length,
	input  logic [4:0]  counter_index,
	output cmd_t        cmd
);

	localparam logic [1:0] ORD_FIRST = 2'd1;
	localparam logic [1:0] ORD_LAST  = 2'd2;

	logic [15:0] rem_q, rem_d;
	logic        summing_q, summing_d;

	always_comb begin
		logic       filtered;
		logic       paired;
		logic [1:0] order;

		cmd            = '0;
		cmd.status     = ST_SKIPPED;
		cmd.seq_len    = seq_len;
		cmd.nm         = nm_value;
		cmd.cig_len    = cigar_length;
		cmd.rd_idx     = counter_index;
		rem_d          = rem_q;
		summing_d      = summing_q;

		filtered = ((flags & cfg.require_mask) != cfg.require_mask) ||
			(|(flags & cfg.exclude_mask)) || (mapq < cfg.mapq_floor);
		paired   = flags[FB_PAIRED];
		order    = paired ? {flags[FB_READ2], flags[FB_READ1]} : ORD_FIRST;

		case (opcode_t'(opcode))
			OP_HEADER: begin
				rem_d     = cigar_count;
				summing_d = 1'b0;
				if (filtered) begin
					cmd.inc[C_FILT] = 1'b1;
					cmd.inc[C_RAW]  = 1'b1;
				end else if (flags[FB_SECONDARY]) begin
					cmd.inc[C_SECONDARY] = 1'b1;
				end else begin
					cmd.inc[C_SUPP] = flags[FB_SUPP];
					if (seq_len != '0) begin
						if (flags[FB_DUP]) begin
							cmd.inc[C_TLENDUP] = 1'b1;
							cmd.inc[C_DUP]     = 1'b1;
						end
						if (!flags[FB_SUPP]) begin
							cmd.inc[C_TLEN]     = 1'b1;
							cmd.inc[C_SEQS]     = 1'b1;
							cmd.inc[C_RAW]      = 1'b1;
							cmd.inc[C_QCFAIL]   = flags[FB_QCFAIL];
							cmd.inc[C_PAIRTECH] = paired;
							if (order == ORD_FIRST) begin
								cmd.inc[C_FIRST] = 1'b1;
								cmd.inc[C_TLEN1] = 1'b1;
							end else if (order == ORD_LAST) begin
								cmd.inc[C_LAST]  = 1'b1;
								cmd.inc[C_TLEN2] = 1'b1;
							end else begin
								cmd.inc[C_OTHER] = 1'b1;
							end
							if (flags[FB_UNMAP]) begin
								cmd.inc[C_UNMAPPED] = 1'b1;
							end else begin
								cmd.inc[C_BMAPPED] = 1'b1;
								cmd.inc[C_MQ0]     = (mapq == '0);
								cmd.inc[C_MAPPED]  = 1'b1;
								if (paired && !flags[FB_MUNMAP]) begin
									cmd.inc[C_PAIRMAP] = 1'b1;
									cmd.inc[C_PROPER]  = flags[FB_PROPER];
									cmd.inc[C_ANOM]    = !same_reference;
								end else begin
									cmd.inc[C_SINGLE] = 1'b1;
								end
							end
						end
						if (flags[FB_UNMAP]) begin
							cmd.status = ST_COUNTED;
						end else begin
							cmd.inc[C_NM] = nm_present;
							if (cigar_count == '0) begin
								cmd.status = ST_NO_CIGAR;
							end else begin
								cmd.status = ST_COUNTED;
								summing_d  = 1'b1;
							end
						end
					end
				end
			end
			OP_CIGAR: begin
				if (rem_q == '0) begin
					cmd.status = ST_BAD_CIGAR;
				end else begin
					cmd.inc[C_BCIGAR] = summing_q && (cigar_op == CIG_M ||
						cigar_op == CIG_I || cigar_op == CIG_EQ || cigar_op == CIG_X);
					cmd.status = summing_q ? ST_COUNTED : ST_SKIPPED;
					rem_d      = rem_q - 16'd1;
					if (rem_q == 16'd1) begin
						summing_d = 1'b0;
					end
				end
			end
			OP_READ: begin
				if (counter_index < 5'(SUM_COUNT)) begin
					cmd.status     = ST_COUNTED;
					cmd.is_counter = 1'b1;
				end
			end
			default: begin
				cmd.status = ST_SKIPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			summing_q <= 1'b0;
		end else if (accept) begin
			rem_q     <= rem_d;
			summing_q <= summing_d;
		end
	end

endmodule

// ===== sv/arsa_back.sv =====
module arsa_back import arsa_pkg::*; #(
	parameter int unsigned CW = CNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hide_filtered,
	input  logic          cmd_valid,
	input  cmd_t          cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic          is_counter,
	output logic [CW-1:0] counter_value
);

	logic [CW-1:0] cnt_q [NCNT];
	logic [CW-1:0] rd_val;
	logic          out_valid_q;
	status_t       status_q;
	logic          is_counter_q;
	logic [CW-1:0] value_q;

	// A beat leaves the queue whenever the output register is free or draining.
	assign pop = cmd_valid && (!out_valid_q || !out_stall);

	for (genvar i = 0; i < NCNT; i++) begin : g_cnt
		logic [CW-1:0] amt;

		always_comb begin
			case (cnt_src(i))
				SRC_LEN: amt = CW'(cmd.seq_len);
				SRC_NM:  amt = CW'(cmd.nm);
				SRC_CIG: amt = CW'(cmd.cig_len);
				default: amt = CW'(1);
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (pop && cmd.inc[i]) begin
				cnt_q[i] <= cnt_q[i] + amt;
			end
		end
	end

	always_comb begin
		case (sum_idx_t'(cmd.rd_idx))
			SUM_RAW_TOTAL:    rd_val = hide_filtered ? cnt_q[C_SEQS] : cnt_q[C_RAW];
			SUM_FILTERED:     rd_val = hide_filtered ? '0 : cnt_q[C_FILT];
			SUM_SEQUENCES:    rd_val = cnt_q[C_SEQS];
			SUM_FIRST:        rd_val = cnt_q[C_FIRST];
			SUM_LAST:         rd_val = cnt_q[C_LAST];
			SUM_OTHER:        rd_val = cnt_q[C_OTHER];
			SUM_MAPPED:       rd_val = cnt_q[C_MAPPED];
			SUM_PAIR_MAPPED:  rd_val = cnt_q[C_PAIRMAP];
			SUM_UNMAPPED:     rd_val = cnt_q[C_UNMAPPED];
			SUM_PROPER:       rd_val = cnt_q[C_PROPER];
			SUM_PAIRED:       rd_val = cnt_q[C_PAIRTECH];
			SUM_DUP:          rd_val = cnt_q[C_DUP];
			SUM_MQ0:          rd_val = cnt_q[C_MQ0];
			SUM_QCFAIL:       rd_val = cnt_q[C_QCFAIL];
			SUM_SECONDARY:    rd_val = cnt_q[C_SECONDARY];
			SUM_SUPP:         rd_val = cnt_q[C_SUPP];
			SUM_DIFF_REF:     rd_val = cnt_q[C_ANOM] >> 1;
			SUM_TOTAL_LEN:    rd_val = cnt_q[C_TLEN];
			SUM_FIRST_LEN:    rd_val = cnt_q[C_TLEN1];
			SUM_LAST_LEN:     rd_val = cnt_q[C_TLEN2];
			SUM_BASES_MAPPED: rd_val = cnt_q[C_BMAPPED];
			SUM_BASES_CIGAR:  rd_val = cnt_q[C_BCIGAR];
			SUM_BASES_DUP:    rd_val = cnt_q[C_TLENDUP];
			SUM_NM:           rd_val = cnt_q[C_NM];
			default:          rd_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q     <= cmd.status;
			is_counter_q <= cmd.is_counter;
			value_q      <= cmd.is_counter ? rd_val : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign is_counter    = is_counter_q;
	assign counter_value = value_q;

endmodule

// ===== sv/alignment_record_stats_accumulator.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// input     | in_valid/in_stall  | opcode, flags, mapq, seq_len, same_reference,
//           |                    | nm_present, nm_value, cigar_count, cigar_op,
//           |                    | cigar_length, counter_index
// output    | out_valid/out_stall| status, is_counter, counter_value
// config    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat per cycle in and out while no stall is raised; each input beat
// yields exactly one output beat, passed through the queue and the output register.
// The decode stage classifies a beat into a counter increment vector; the
// queue (QUEUE_DEPTH beats) decouples it from the counter bank and output register.
// in_stall rises only when the queue is full. Reset clears all counters at once.
module alignment_record_stats_accumulator import arsa_pkg::*; #(
	parameter int unsigned COUNTER_WIDTH = CNT_WIDTH_DEF,
	parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               opcode,
	input  logic [11:0]              flags,
	input  logic [7:0]               mapq,
	input  logic [23:0]              seq_len,
	input  logic                     same_reference,
	input  logic                     nm_present,
	input  logic [23:0]              nm_value,
	input  logic [15:0]              cigar_count,
	input  logic [3:0]               cigar_op,
	input  logic [27:0]              cigar_length,
	input  logic [4:0]               counter_index,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic                     is_counter,
	output logic [COUNTER_WIDTH-1:0] counter_value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [3:0]               cfg_index,
	input  logic [11:0]              cfg_data
);

	filt_cfg_t cfg_q;
	logic      hide_q;
	logic      accept;
	logic      q_full;
	logic      q_nonempty;
	logic      q_pop;
	cmd_t      cmd_in;
	cmd_t      cmd_out;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= '0;
			hide_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_MAPQ: cfg_q.mapq_floor   <= cfg_data[7:0];
				CFG_REQUIRE:  cfg_q.require_mask <= cfg_data;
				CFG_EXCLUDE:  cfg_q.exclude_mask <= cfg_data;
				CFG_HIDE:     hide_q             <= cfg_data[0];
				default:      hide_q             <= hide_q;
			endcase
		end
	end

	arsa_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cfg            (cfg_q),
		.opcode         (opcode),
		.flags          (flags),
		.mapq           (mapq),
		.seq_len        (seq_len),
		.same_reference (same_reference),
		.nm_present     (nm_present),
		.nm_value       (nm_value),
		.cigar_count    (cigar_count),
		.cigar_op       (cigar_op),
		.cigar_length   (cigar_length),
		.counter_index  (counter_index),
		.cmd            (cmd_in)
	);

	arsa_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wdata    (cmd_in),
		.full     (q_full),
		.pop      (q_pop),
		.rdata    (cmd_out),
		.nonempty (q_nonempty)
	);

	arsa_back #(
		.CW (COUNTER_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.hide_filtered (hide_q),
		.cmd_valid     (q_nonempty),
		.cmd           (cmd_out),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.is_counter    (is_counter),
		.counter_value (counter_value)
	);

endmodule
